@@ sv/qmm_pkg.sv @@
`default_nettype none
package qmm_pkg;

    // Field widths
    localparam int unsigned ModeW  = 3;
    localparam int unsigned SpeedW = 10;
    localparam int unsigned CorrW  = 16;
    localparam int unsigned StepW  = 6;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned NumMotors = 4;
    // Wide mix width: throttle plus four 16-bit terms never overflows this
    localparam int unsigned MixW   = 19;
    // Ramp width: held speed minus step, signed
    localparam int unsigned RampW  = 12;

    // Flight modes
    localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
    localparam logic [ModeW-1:0] MODE_NORMAL  = 3'd1;
    localparam logic [ModeW-1:0] MODE_FIXHGT  = 3'd2;
    localparam logic [ModeW-1:0] MODE_DESCENT = 3'd3;
    localparam logic [ModeW-1:0] MODE_FAIL    = 3'd4;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_CEILING = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_YAW     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_CUTOFF  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_STEP    = 2'd3;

    // Register reset values
    localparam logic [SpeedW-1:0] CEILING_RST = 10'd650;
    localparam logic [SpeedW-1:0] YAW_RST     = 10'd100;
    localparam logic [SpeedW-1:0] CUTOFF_RST  = 10'd50;
    localparam logic [StepW-1:0]  STEP_RST    = 6'd2;

    typedef logic [SpeedW-1:0] t_speed;

    typedef struct packed {
        logic [ModeW-1:0]        mode;
        logic [SpeedW-1:0]       thr;
        logic signed [CorrW-1:0] pitch;
        logic signed [CorrW-1:0] roll;
        logic signed [CorrW-1:0] yaw;
        logic signed [CorrW-1:0] height;
        logic                    slow;
    } t_item;

    typedef struct packed {
        logic [SpeedW-1:0] ceiling;
        logic [SpeedW-1:0] yaw_lim;
        logic [SpeedW-1:0] cutoff;
        logic [StepW-1:0]  step;
    } t_cfg;

    typedef struct packed {
        t_speed [NumMotors-1:0] speed;
        logic                   desc_pend;
        logic                   fail_pend;
        logic                   slow_hist;
        logic                   idle_ok;
    } t_state;

    // Clamp a wide signed value into 0..ceiling
    function automatic t_speed sat_speed(input logic signed [MixW-1:0] v,
                                         input logic [SpeedW-1:0] ceiling);
        logic signed [MixW-1:0] hi;
        hi = signed'({{(MixW-SpeedW){1'b0}}, ceiling});
        if (v < 0)
            return '0;
        else if (v > hi)
            return ceiling;
        else
            return v[SpeedW-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/quad_motor_mixer_with_rampdown.sv @@
// X-pattern quadcopter motor mixer with descent and failure ramp-down.
// Input channel (i_valid/o_ready) carries one control tick: flight mode,
// throttle, four signed corrections and the slow-descent request. Output
// channel (o_valid/i_ready) returns four motor speeds plus the idle-allowed
// level and the fail-done pulse, one result word per input word.
// Path: an accepted word is held in one input register, then passes through
// the mixing and clamping logic into the result register, which sets o_valid.
// A new word is taken every cycle unless stalled; the held motor speeds feed
// back from the result register, so each tick sees the previous tick's speeds.
// When the receiver stalls, the result register holds its word and the input
// register absorbs one more word; o_ready drops only with both full.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once
// and are to be made while no word is in flight.
// Reset (synchronous, active low) empties both stages, zeroes the held speeds,
// arms both averaging flags and restores the register defaults.
`default_nettype none
module quad_motor_mixer_with_rampdown (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [qmm_pkg::CfgIdxW-1:0]           i_cfg_idx,
    input  logic [qmm_pkg::SpeedW-1:0]            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [qmm_pkg::ModeW-1:0]             i_flight_mode,
    input  logic [qmm_pkg::SpeedW-1:0]            i_throttle,
    input  logic signed [qmm_pkg::CorrW-1:0]      i_pitch_correction,
    input  logic signed [qmm_pkg::CorrW-1:0]      i_roll_correction,
    input  logic signed [qmm_pkg::CorrW-1:0]      i_yaw_correction,
    input  logic signed [qmm_pkg::CorrW-1:0]      i_height_correction,
    input  logic                                  i_slow_request,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [qmm_pkg::SpeedW-1:0]            o_front_left_speed,
    output logic [qmm_pkg::SpeedW-1:0]            o_rear_left_speed,
    output logic [qmm_pkg::SpeedW-1:0]            o_front_right_speed,
    output logic [qmm_pkg::SpeedW-1:0]            o_rear_right_speed,
    output logic                                  o_idle_allowed,
    output logic                                  o_fail_done
);
    import qmm_pkg::*;

    t_cfg   r_cfg;
    t_item  r_item;
    logic   r_in_vld;
    t_state r_state;
    logic   r_out_vld;
    logic   r_fail_done;
    t_state n_state;
    logic   n_fail_done;
    logic   advance;

    // Move the input word into the result register when it has room
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ceiling <= CEILING_RST;
            r_cfg.yaw_lim <= YAW_RST;
            r_cfg.cutoff  <= CUTOFF_RST;
            r_cfg.step    <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CEILING: r_cfg.ceiling <= i_cfg_data;
                REG_YAW:     r_cfg.yaw_lim <= i_cfg_data;
                REG_CUTOFF:  r_cfg.cutoff  <= i_cfg_data;
                REG_STEP:    r_cfg.step    <= i_cfg_data[StepW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.mode   <= i_flight_mode;
            r_item.thr    <= i_throttle;
            r_item.pitch  <= i_pitch_correction;
            r_item.roll   <= i_roll_correction;
            r_item.yaw    <= i_yaw_correction;
            r_item.height <= i_height_correction;
            r_item.slow   <= i_slow_request;
        end
    end

    qmm_core u_core (
        .i_item      (r_item),
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .o_state     (n_state),
        .o_fail_done (n_fail_done)
    );

    // Result register doubles as the held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld         <= 1'b0;
            r_fail_done       <= 1'b0;
            r_state.speed     <= '0;
            r_state.desc_pend <= 1'b1;
            r_state.fail_pend <= 1'b1;
            r_state.slow_hist <= 1'b0;
            r_state.idle_ok   <= 1'b0;
        end else begin
            if (advance) begin
                r_out_vld   <= 1'b1;
                r_state     <= n_state;
                r_fail_done <= n_fail_done;
            end else if (i_ready) begin
                r_out_vld   <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_vld;
    assign o_front_left_speed  = r_state.speed[0];
    assign o_rear_left_speed   = r_state.speed[1];
    assign o_front_right_speed = r_state.speed[2];
    assign o_rear_right_speed  = r_state.speed[3];
    assign o_idle_allowed      = r_state.idle_ok;
    assign o_fail_done         = r_fail_done;

endmodule
`default_nettype wire

@@ sv/qmm_core.sv @@
`default_nettype none
module qmm_core (
    input  qmm_pkg::t_item  i_item,
    input  qmm_pkg::t_state i_state,
    input  qmm_pkg::t_cfg   i_cfg,
    output qmm_pkg::t_state o_state,
    output logic            o_fail_done
);
    import qmm_pkg::*;

    logic signed [CorrW:0]   yaw_lim;
    logic signed [CorrW:0]   yaw_ext;
    logic signed [CorrW:0]   yaw_c;
    logic signed [MixW-1:0]  thr_w, p_w, r_w, y_w, h_w;
    logic signed [MixW-1:0]  mix [NumMotors];
    logic signed [MixW-1:0]  sp  [NumMotors];
    logic                    edge_up;
    logic                    pend_in;
    logic [SpeedW+1:0]       sum4;
    logic [SpeedW-1:0]       avg;
    logic signed [RampW-1:0] ramp [NumMotors];
    logic                    ramp_done;
    logic                    kill;

    // Clamp yaw to +/- limit
    always_comb begin
        yaw_lim = signed'({{(CorrW+1-SpeedW){1'b0}}, i_cfg.yaw_lim});
        yaw_ext = {i_item.yaw[CorrW-1], i_item.yaw};
        if (yaw_ext > yaw_lim)
            yaw_c = yaw_lim;
        else if (yaw_ext < -yaw_lim)
            yaw_c = -yaw_lim;
        else
            yaw_c = yaw_ext;
    end

    // X-pattern mix in wide signed arithmetic
    always_comb begin
        thr_w = signed'({{(MixW-SpeedW){1'b0}}, i_item.thr});
        p_w   = MixW'(i_item.pitch);
        r_w   = MixW'(i_item.roll);
        y_w   = MixW'(yaw_c);
        h_w   = (i_item.mode == MODE_FIXHGT) ? MixW'(i_item.height) : '0;
        mix[0] = thr_w + p_w - r_w + y_w + h_w;
        mix[1] = thr_w - p_w - r_w - y_w + h_w;
        mix[2] = thr_w + p_w + r_w - y_w + h_w;
        mix[3] = thr_w - p_w + r_w + y_w + h_w;
    end

    // Ramp: optional average, then subtract step
    always_comb begin
        edge_up = i_item.slow && !i_state.slow_hist;
        if (i_item.mode == MODE_DESCENT)
            pend_in = i_state.desc_pend || edge_up;
        else
            pend_in = i_state.fail_pend;
        sum4 = {2'b00, i_state.speed[0]} + {2'b00, i_state.speed[1]}
             + {2'b00, i_state.speed[2]} + {2'b00, i_state.speed[3]};
        avg  = sum4[SpeedW+1:2];
        ramp_done = 1'b1;
        for (int k = 0; k < NumMotors; k++) begin
            ramp[k] = signed'({{(RampW-SpeedW){1'b0}},
                               pend_in ? avg : i_state.speed[k]})
                    - signed'({{(RampW-StepW){1'b0}}, i_cfg.step});
            if (ramp[k] > 0)
                ramp_done = 1'b0;
        end
    end

    // Select by mode and update flags
    always_comb begin
        o_state     = i_state;
        o_fail_done = 1'b0;
        for (int k = 0; k < NumMotors; k++)
            sp[k] = signed'({{(MixW-SpeedW){1'b0}}, i_state.speed[k]});
        unique case (i_item.mode)
            MODE_IDLE: begin
                for (int k = 0; k < NumMotors; k++)
                    sp[k] = '0;
            end
            MODE_NORMAL, MODE_FIXHGT: begin
                for (int k = 0; k < NumMotors; k++)
                    sp[k] = mix[k];
            end
            MODE_DESCENT: begin
                for (int k = 0; k < NumMotors; k++)
                    sp[k] = MixW'(ramp[k]);
                o_state.desc_pend = ramp_done;
                o_state.slow_hist = i_item.slow;
                if (ramp_done)
                    o_state.idle_ok = 1'b1;
                else if (edge_up)
                    o_state.idle_ok = 1'b0;
            end
            MODE_FAIL: begin
                for (int k = 0; k < NumMotors; k++)
                    sp[k] = MixW'(ramp[k]);
                o_state.fail_pend = ramp_done;
                o_fail_done       = ramp_done;
            end
            default: begin
            end
        endcase
        // Clamp and apply throttle cutoff
        kill = (i_item.thr <= i_cfg.cutoff);
        for (int k = 0; k < NumMotors; k++)
            o_state.speed[k] = kill ? '0 : sat_speed(sp[k], i_cfg.ceiling);
    end

endmodule
`default_nettype wire

@@ sv/qmm_checker.sv @@
`default_nettype none
module qmm_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_ready,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [qmm_pkg::SpeedW-1:0]       o_front_left_speed,
    input  logic [qmm_pkg::SpeedW-1:0]       o_rear_left_speed,
    input  logic [qmm_pkg::SpeedW-1:0]       o_front_right_speed,
    input  logic [qmm_pkg::SpeedW-1:0]       o_rear_right_speed,
    input  logic                             o_idle_allowed,
    input  logic                             o_fail_done
);

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_front_left_speed)
            && $stable(o_rear_left_speed) && $stable(o_front_right_speed)
            && $stable(o_rear_right_speed) && $stable(o_fail_done)
            && $stable(o_idle_allowed))
        else $error("result word changed while stalled");

    // Input backpressure only with a stalled full result register
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output stall");

    // Finished fail ramp leaves all motors at zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fail_done |-> o_front_left_speed == '0
            && o_rear_left_speed == '0 && o_front_right_speed == '0
            && o_rear_right_speed == '0)
        else $error("fail done with nonzero speed");

    // No result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind quad_motor_mixer_with_rampdown qmm_checker u_qmm_checker (.*);
`default_nettype wire
